// File: rtl/srpp_pkg.sv
// Shared constants and controller/datapath interface types for the shelf packer.
// No dependencies; imported by every module of the block.
package srpp_pkg;

  localparam int MAX_RECTS_DEF = 64;
  localparam int MIN_SIDE_DEF  = 64;
  localparam int MAX_SIDE_DEF  = 8192;

  localparam int DIM_W  = 14;  // rectangle width/height, positions, reported side
  localparam int NUM_W  = 6;   // rect_number field
  localparam int GAP_W  = 8;
  localparam int SIDE_W = 16;  // trial side, room for one doubling past 16384
  localparam int SUM_W  = 18;  // cursor + size + gap sums

  localparam logic [GAP_W-1:0] GAP_RST = 8'd2;

  // configuration register byte offsets
  localparam logic [1:0] GAP_ADDR = 2'd0;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic load;       // store an input transfer
    logic pack_init;  // first trial side, cursors cleared
    logic retry;      // double the side, restart the pass
    logic wrap;       // row-wrap step for the current rectangle
    logic place;      // height check passed: record position, advance
    logic emit_init;  // rewind the index for result output
    logic emit;       // load one placement into the output register
    logic fail;       // load the failure result
  } srpp_cmd_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic fit;       // current rectangle fits vertically at the current side
    logic last;      // index points at the last stored rectangle
    logic side_end;  // doubling the side would pass the maximum
    logic out_free;  // output register can take a result this cycle
  } srpp_sts_t;

endpackage

// File: rtl/srpp_ctrl.sv
// Sequencer for the shelf packer: load, pack passes over trial sides, result output.
// Depends on srpp_pkg for the command and status structs.
module srpp_ctrl
  import srpp_pkg::*;
#(
  parameter int MIN_SIDE = MIN_SIDE_DEF,
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_final_rect,
  output logic      in_stall,
  input  srpp_sts_t sts,
  output srpp_cmd_t cmd
);

  localparam bit NO_SIDE = (MIN_SIDE > MAX_SIDE);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_PK_RD    = 7'b0000010,
    S_PK_WRAP  = 7'b0000100,
    S_PK_PLACE = 7'b0001000,
    S_EM_RD    = 7'b0010000,
    S_EM_OUT   = 7'b0100000,
    S_FAIL     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_final_rect) begin
            cmd.pack_init = 1'b1;
            state_nxt     = NO_SIDE ? S_FAIL : S_PK_RD;
          end
        end
      end
      S_PK_RD:   state_nxt = S_PK_WRAP;  // store read in flight
      S_PK_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = S_PK_PLACE;
      end
      S_PK_PLACE: begin
        if (sts.fit) begin
          cmd.place = 1'b1;
          if (sts.last) begin
            cmd.emit_init = 1'b1;
            state_nxt     = S_EM_RD;
          end else begin
            state_nxt = S_PK_RD;
          end
        end else if (sts.side_end) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.retry = 1'b1;
          state_nxt = S_PK_RD;
        end
      end
      S_EM_RD:   state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last ? S_IDLE : S_EM_RD;
        end
      end
      S_FAIL: begin
        if (sts.out_free) begin
          cmd.fail  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/srpp_dp.sv
// Datapath of the shelf packer: size store, placement store, cursors, output register.
// Depends on srpp_pkg; driven by srpp_ctrl through srpp_cmd_t.
module srpp_dp
  import srpp_pkg::*;
#(
  parameter int MAX_RECTS = MAX_RECTS_DEF,
  parameter int MIN_SIDE  = MIN_SIDE_DEF,
  parameter int MAX_SIDE  = MAX_SIDE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  srpp_cmd_t        cmd,
  output srpp_sts_t        sts,
  input  logic [GAP_W-1:0] gap,
  input  logic [DIM_W-1:0] in_rect_width,
  input  logic [DIM_W-1:0] in_rect_height,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_fits,
  output logic [DIM_W-1:0] out_atlas_side,
  output logic [NUM_W-1:0] out_rect_number,
  output logic [DIM_W-1:0] out_pos_x,
  output logic [DIM_W-1:0] out_pos_y,
  output logic             out_run_end
);

  localparam int IDXW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNTW = $clog2(MAX_RECTS + 1);

  // {width, height} and {x, y}
  logic [2*DIM_W-1:0] dim_mem   [MAX_RECTS];
  logic [2*DIM_W-1:0] place_mem [MAX_RECTS];
  logic [2*DIM_W-1:0] dim_rd_r, place_rd_r;

  logic [CNTW-1:0]   count_r;
  logic [IDXW-1:0]   idx_r;
  logic [SIDE_W-1:0] side_r;
  logic [14:0]       cx_r;   // stays below 16639
  logic [15:0]       cy_r;   // stays below 33023
  logic [DIM_W-1:0]  sh_r;

  logic             out_valid_r, out_fits_r, out_run_end_r;
  logic [DIM_W-1:0] out_side_r, out_x_r, out_y_r;
  logic [NUM_W-1:0] out_num_r;

  logic [DIM_W-1:0] cur_w, cur_h;
  logic [SUM_W-1:0] xsum, ysum, yfit_sum;
  logic             wrap;
  logic             out_free;
  logic             store_ok;

  assign cur_w = dim_rd_r[2*DIM_W-1:DIM_W];
  assign cur_h = dim_rd_r[DIM_W-1:0];

  assign xsum     = SUM_W'(cx_r) + SUM_W'(cur_w) + SUM_W'(gap);
  assign ysum     = SUM_W'(cy_r) + SUM_W'(sh_r) + SUM_W'(gap);
  assign yfit_sum = SUM_W'(cy_r) + SUM_W'(cur_h) + SUM_W'(gap);
  assign wrap     = xsum > SUM_W'(side_r);

  assign out_free = !out_valid_r || !out_stall;
  assign store_ok = count_r < CNTW'(MAX_RECTS);

  assign sts.fit      = yfit_sum <= SUM_W'(side_r);
  assign sts.last     = (CNTW'(idx_r) + CNTW'(1)) == count_r;
  assign sts.side_end = {side_r, 1'b0} > (SIDE_W + 1)'(MAX_SIDE);
  assign sts.out_free = out_free;

  // stores: one write port, registered read at the running index
  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      dim_mem[count_r[IDXW-1:0]] <= {in_rect_width, in_rect_height};
    end
    dim_rd_r <= dim_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      place_mem[idx_r] <= {cx_r[DIM_W-1:0], cy_r[DIM_W-1:0]};
    end
    place_rd_r <= place_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      side_r  <= SIDE_W'(MIN_SIDE);
      cx_r    <= '0;
      cy_r    <= '0;
      sh_r    <= '0;
    end else begin
      if (cmd.load && store_ok) begin
        count_r <= count_r + CNTW'(1);
      end
      if (cmd.fail || (cmd.emit && sts.last)) begin
        count_r <= '0;
      end

      if (cmd.pack_init || cmd.retry) begin
        side_r <= cmd.pack_init ? SIDE_W'(MIN_SIDE) : {side_r[SIDE_W-2:0], 1'b0};
        idx_r  <= '0;
        cx_r   <= '0;
        cy_r   <= '0;
        sh_r   <= '0;
      end

      if (cmd.wrap && wrap) begin
        cx_r <= '0;
        cy_r <= ysum[15:0];
        sh_r <= '0;
      end

      if (cmd.place) begin
        cx_r  <= xsum[14:0];
        sh_r  <= (cur_h > sh_r) ? cur_h : sh_r;
        idx_r <= idx_r + IDXW'(1);
      end

      if (cmd.emit_init) begin
        idx_r <= '0;
      end else if (cmd.emit) begin
        idx_r <= idx_r + IDXW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.fail) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_fits_r    <= 1'b1;
      out_side_r    <= side_r[DIM_W-1:0];
      out_num_r     <= NUM_W'(idx_r);
      out_x_r       <= place_rd_r[2*DIM_W-1:DIM_W];
      out_y_r       <= place_rd_r[DIM_W-1:0];
      out_run_end_r <= sts.last;
    end else if (cmd.fail) begin
      out_fits_r    <= 1'b0;
      out_side_r    <= '0;
      out_num_r     <= '0;
      out_x_r       <= '0;
      out_y_r       <= '0;
      out_run_end_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fits        = out_fits_r;
  assign out_atlas_side  = out_side_r;
  assign out_rect_number = out_num_r;
  assign out_pos_x       = out_x_r;
  assign out_pos_y       = out_y_r;
  assign out_run_end     = out_run_end_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(MAX_RECTS))
    else $error("rect count above store depth");

  a_place_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.place || cmd.emit) |-> (CNTW'(idx_r) < count_r))
    else $error("index outside stored set");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.fail) |-> out_free)
    else $error("output register overwritten");

  a_run_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fail || (cmd.emit && sts.last)) |=> (count_r == '0) && out_valid_r && out_run_end_r)
    else $error("run end not flagged or count not cleared");

endmodule

// File: rtl/shelf_rect_packer_pow2_unit.sv
// Top level of the power-of-two square shelf packer: gap register, controller, datapath.
// Depends on srpp_pkg, srpp_ctrl and srpp_dp.

// Rectangles are loaded one transfer per cycle while in_stall is low and stored in load
// order (up to MAX_RECTS; extras are dropped). The transfer with final_rect set starts
// packing and the input stays stalled until the last result of that run sits in the
// output register. Packing tries square sides MIN_SIDE, 2*MIN_SIDE, ... up to MAX_SIDE;
// for each trial side every rectangle goes through a store read, a row wrap, then a
// height check and place, and a side stops at the first rectangle that does not fit.
// Then one result per rectangle follows, or one failure result. The padding register
// gap (offset 0, reset 2) must be written by the user only between runs; the block
// itself does not enforce this.
module shelf_rect_packer_pow2_unit
  import srpp_pkg::*;
#(
  parameter int MAX_RECTS = MAX_RECTS_DEF,
  parameter int MIN_SIDE  = MIN_SIDE_DEF,
  parameter int MAX_SIDE  = MAX_SIDE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // rectangle input
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [DIM_W-1:0] in_rect_width,
  input  logic [DIM_W-1:0] in_rect_height,
  input  logic             in_final_rect,
  // placement results
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_fits,
  output logic [DIM_W-1:0] out_atlas_side,
  output logic [NUM_W-1:0] out_rect_number,
  output logic [DIM_W-1:0] out_pos_x,
  output logic [DIM_W-1:0] out_pos_y,
  output logic             out_run_end
);

  logic [GAP_W-1:0] gap_r;
  srpp_cmd_t        cmd;
  srpp_sts_t        sts;

  assign pready = 1'b1;

  // gap is the only register; writes ignore paddr
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= GAP_RST;
    end else if (psel && penable && pwrite && pready) begin
      gap_r <= pwdata[GAP_W-1:0];
    end
  end

  assign prdata = (paddr == GAP_ADDR) ? {{(32 - GAP_W){1'b0}}, gap_r} : '0;

  srpp_ctrl #(
    .MIN_SIDE (MIN_SIDE),
    .MAX_SIDE (MAX_SIDE)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_final_rect (in_final_rect),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  srpp_dp #(
    .MAX_RECTS (MAX_RECTS),
    .MIN_SIDE  (MIN_SIDE),
    .MAX_SIDE  (MAX_SIDE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .gap             (gap_r),
    .in_rect_width   (in_rect_width),
    .in_rect_height  (in_rect_height),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fits        (out_fits),
    .out_atlas_side  (out_atlas_side),
    .out_rect_number (out_rect_number),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_run_end     (out_run_end)
  );

endmodule

// File: tb/sv/shelf_rect_packer_pow2_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for shelf_rect_packer_pow2_unit: streams rectangle sets, predicts
// every placement transfer in-bench and checks results in order. Depends on srpp_pkg and the RTL.
module shelf_rect_packer_pow2_unit_tb
  import srpp_pkg::*;
();

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_MAX = 10;

  typedef enum int {SZ_TINY, SZ_SMALL, SZ_MID, SZ_LEGAL, SZ_WILD} size_mode_t;

  typedef struct {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             fin;
    bit               drain;  // hold this rect back until all placements are out
  } rect_item_t;

  typedef struct packed {
    logic             fits;
    logic [DIM_W-1:0] side;
    logic [NUM_W-1:0] num;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic             last;
  } placement_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [1:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [DIM_W-1:0] in_rect_width = '0;
  logic [DIM_W-1:0] in_rect_height = '0;
  logic             in_final_rect = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_fits;
  logic [DIM_W-1:0] out_atlas_side;
  logic [NUM_W-1:0] out_rect_number;
  logic [DIM_W-1:0] out_pos_x;
  logic [DIM_W-1:0] out_pos_y;
  logic             out_run_end;

  // predictor state
  logic [DIM_W-1:0] width_mem [MAX_RECTS_DEF];
  logic [DIM_W-1:0] height_mem [MAX_RECTS_DEF];
  int unsigned      stored_cnt = 0;
  logic [31:0]      gap_cfg = 32'(GAP_RST);

  rect_item_t rect_queue[$];
  placement_t placements_due[$];
  rect_item_t next_rect;
  placement_t seen_res;
  placement_t due_res;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  shelf_rect_packer_pow2_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_final_rect  (in_final_rect),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_fits       (out_fits),
    .out_atlas_side (out_atlas_side),
    .out_rect_number(out_rect_number),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_run_end    (out_run_end)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void note_failure(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX) $display("%s", msg);
  endfunction

  // Store one rect; on the final one shelf-pack the set at growing sides and queue placements.
  function automatic void load_and_pack(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                        input logic fin);
    logic [31:0] side, cx, cy, shelf, wi, hi;
    logic [31:0] px [MAX_RECTS_DEF];
    logic [31:0] py [MAX_RECTS_DEF];
    int          i;
    bit          fits_all;
    bit          found;
    placement_t  p;
    if (stored_cnt < MAX_RECTS_DEF) begin
      width_mem[stored_cnt] = w;
      height_mem[stored_cnt] = h;
      stored_cnt++;
    end
    if (!fin) return;
    found = 0;
    side = MIN_SIDE_DEF;
    while (!found && side <= MAX_SIDE_DEF) begin
      cx = 0;
      cy = 0;
      shelf = 0;
      fits_all = 1;
      for (i = 0; i < stored_cnt && fits_all; i++) begin
        wi = 32'(width_mem[i]);
        hi = 32'(height_mem[i]);
        // width is only checked before a wrap, never after
        if (cx + wi + gap_cfg > side) begin
          cx = 0;
          cy = cy + shelf + gap_cfg;
          shelf = 0;
        end
        if (cy + hi + gap_cfg > side) begin
          fits_all = 0;
        end else begin
          px[i] = cx;
          py[i] = cy;
          if (hi > shelf) shelf = hi;
          cx = cx + wi + gap_cfg;
        end
      end
      if (fits_all) found = 1;
      else side = side * 2;
    end
    if (!found || stored_cnt == 0) begin
      p = '0;
      p.last = 1'b1;
      placements_due.insert(placements_due.size(), p);
    end else begin
      for (i = 0; i < stored_cnt; i++) begin
        p.fits = 1'b1;
        p.side = side[DIM_W-1:0];
        p.num = i[NUM_W-1:0];
        p.x = px[i][DIM_W-1:0];
        p.y = py[i][DIM_W-1:0];
        p.last = (i + 1 == stored_cnt);
        placements_due.insert(placements_due.size(), p);
      end
    end
    stored_cnt = 0;
  endfunction

  // rect driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rect_width <= '0;
      in_rect_height <= '0;
      in_final_rect <= 1'b0;
    end else begin
      if (in_valid && !in_stall) load_and_pack(in_rect_width, in_rect_height, in_final_rect);
      if (!in_valid || !in_stall) begin
        if (rect_queue.size() != 0 && !(rect_queue[0].drain && placements_due.size() != 0)
            && $urandom_range(99) >= send_idle_pct) begin
          next_rect = rect_queue.pop_front();
          in_valid <= 1'b1;
          in_rect_width <= next_rect.w;
          in_rect_height <= next_rect.h;
          in_final_rect <= next_rect.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // placement monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_res = {out_fits, out_atlas_side, out_rect_number, out_pos_x, out_pos_y,
                    out_run_end};
        if (placements_due.size() == 0) begin
          note_failure($sformatf({"unexpected placement: fits=%0d side=%0d rect=%0d ",
                                  "x=%0d y=%0d end=%0d"},
                                 seen_res.fits, seen_res.side, seen_res.num, seen_res.x,
                                 seen_res.y, seen_res.last));
        end else begin
          due_res = placements_due.pop_front();
          if (seen_res !== due_res)
            note_failure($sformatf({"placement mismatch: expected fits=%0d side=%0d rect=%0d ",
                                    "x=%0d y=%0d end=%0d, got fits=%0d side=%0d rect=%0d ",
                                    "x=%0d y=%0d end=%0d"},
                                   due_res.fits, due_res.side, due_res.num, due_res.x,
                                   due_res.y, due_res.last, seen_res.fits, seen_res.side,
                                   seen_res.num, seen_res.x, seen_res.y, seen_res.last));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("shelf_rect_packer_pow2_unit_tb failed");
      $finish;
    end
  end

  task automatic add_rect(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                          input logic fin, input bit drain);
    rect_item_t r;
    r.w = w;
    r.h = h;
    r.fin = fin;
    r.drain = drain;
    rect_queue.insert(rect_queue.size(), r);
  endtask

  function automatic logic [DIM_W-1:0] rand_dim(input size_mode_t mode);
    case (mode)
      SZ_TINY:  return DIM_W'($urandom_range(1, 40));
      SZ_SMALL: return DIM_W'($urandom_range(1, 300));
      SZ_MID:   return DIM_W'($urandom_range(1, 2000));
      SZ_LEGAL: return DIM_W'($urandom_range(1, MAX_SIDE_DEF));
      default:  return DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
    endcase
  endfunction

  task automatic queue_random_sets(input int item_budget, input bit add_full_set);
    int         total;
    int         n;
    int         k;
    int         pick;
    bit         drain;
    size_mode_t mode;
    total = 0;
    if (add_full_set) begin
      // overfill the store: the extra rects are dropped, the last still starts packing
      for (k = 0; k < MAX_RECTS_DEF + 3; k++)
        add_rect(rand_dim(SZ_TINY), rand_dim(SZ_TINY), k == MAX_RECTS_DEF + 2, 0);
      total = MAX_RECTS_DEF + 3;
    end
    while (total < item_budget) begin
      n = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      pick = $urandom_range(9);
      if (pick < 5) mode = SZ_TINY;
      else if (pick < 7) mode = SZ_SMALL;
      else if (pick == 7) mode = SZ_MID;
      else if (pick == 8) mode = SZ_LEGAL;
      else mode = SZ_WILD;
      drain = ($urandom_range(11) == 0);
      for (k = 0; k < n; k++)
        add_rect(rand_dim(mode), rand_dim(mode), k == n - 1, drain && k == 0);
      total += n;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (rect_queue.size() != 0 || in_valid || placements_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the gap register, then read it back
  task automatic set_gap(input logic [GAP_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= GAP_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    gap_cfg = 32'(value);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {{(32 - GAP_W){1'b0}}, value})
      note_failure($sformatf("gap readback: expected %0d, got %0d", value, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed sets at the reset gap, no idling
    add_rect(1, 1, 1, 0);
    add_rect(8190, 8190, 1, 0);                // fills the largest side exactly
    add_rect(DIM_W'(MAX_SIDE_DEF), DIM_W'(MAX_SIDE_DEF), 1, 0);  // fits no side
    add_rect(0, 0, 1, 0);
    add_rect(14'h3FFF, 1, 1, 0);               // too wide, but placed after the wrap
    add_rect(14'h2AAA, 14'h1555, 1, 0);
    add_rect(14'h1555, 14'h2AAA, 1, 0);
    add_rect(62, 10, 0, 1);                    // first shelf wraps on the second rect
    add_rect(30, 20, 0, 0);
    add_rect(30, 5, 1, 0);
    add_rect(10, 10, 0, 0);
    add_rect(100, 10, 1, 0);
    add_rect(50, 60, 0, 0);                    // height forces a doubling
    add_rect(50, 60, 1, 0);
    add_rect(4000, 100, 0, 0);
    add_rect(4000, 100, 0, 0);
    add_rect(100, 8000, 1, 0);
    wait_drained();

    set_gap(0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random_sets(90, 1);
    wait_drained();

    set_gap(8'hFF);
    send_idle_pct = 83;
    recv_stall_pct = 0;
    queue_random_sets(45, 0);
    wait_drained();

    set_gap(GAP_W'($urandom_range(1, 254)));
    send_idle_pct = 0;
    recv_stall_pct = 83;
    queue_random_sets(45, 0);
    wait_drained();

    set_gap(GAP_W'($urandom_range(1, 254)));
    send_idle_pct = 31;
    recv_stall_pct = 31;
    queue_random_sets(45, 0);
    wait_drained();

    if (placements_due.size() != 0)
      note_failure($sformatf("%0d placements never arrived", placements_due.size()));
    if (mismatch_cnt == 0) begin
      $display("shelf_rect_packer_pow2_unit_tb passed");
    end else begin
      $display("shelf_rect_packer_pow2_unit_tb failed");
    end
    $finish;
  end

endmodule
